// ===== sv/smbseq_pkg.sv =====
// Shared types and codes for the SMBus master transaction sequencer.
// No dependencies; every other file refers to this package by scoped names.
package smbseq_pkg;

	// Event kinds carried by an input request
	typedef enum logic [1:0] {
		KIND_REQUEST = 2'd0,
		KIND_STEP    = 2'd1,
		KIND_TIMEOUT = 2'd2
	} kind_t;

	// Transaction types
	typedef enum logic [1:0] {
		OP_WRITE_BYTE = 2'd0,
		OP_READ_BYTE  = 2'd1,
		OP_WRITE_CMD  = 2'd2,
		OP_CMD_READ   = 2'd3
	} op_t;

	// Bus actions issued to the bit-level engine
	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_START = 3'd1,
		ACT_SEND  = 3'd2,
		ACT_RECV  = 3'd3,
		ACT_STOP  = 3'd4
	} action_t;

	// Completion status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ADDR_NACK = 3'd1,
		ST_BYTE2_NACK = 3'd2,
		ST_BYTE3_NACK = 3'd3,
		ST_TIMEOUT   = 3'd4,
		ST_BUSY      = 3'd5
	} status_t;

	// Transaction phases
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_START  = 4'd1,
		PH_ADDR   = 4'd2,
		PH_CMD    = 4'd3,
		PH_DATA   = 4'd4,
		PH_RSTART = 4'd5,
		PH_RADDR  = 4'd6,
		PH_RECV   = 4'd7
	} phase_t;

	localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
	localparam logic [7:0] ADDR_READ_BIT   = 8'h01;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] operation;
		logic [6:0] target_addr;
		logic [7:0] command;
		logic [7:0] write_data;
		logic       ack_seen;
		logic [7:0] received_byte;
	} req_t;

	typedef struct packed {
		action_t    bus_action;
		logic [7:0] bus_byte;
		logic       done_res;
		status_t    status;
		logic [7:0] read_data;
	} res_t;

endpackage

// ===== sv/smbseq_in_reg.sv =====
// Input register stage of the SMBus sequencer.
// Depends on smbseq_pkg for the request struct.
module smbseq_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  smbseq_pkg::req_t   req,
	input  logic               out_ready,
	output logic               valid_s1,
	output smbseq_pkg::req_t   req_s1
);

	// hold the request while the result side cannot take it
	assign in_stall = valid_s1 && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1 <= req;
		end
	end

endmodule

// ===== sv/smbseq_core.sv =====
// Phase state machine and held request fields of the SMBus sequencer.
// Depends on smbseq_pkg for codes, phase enum and request/result structs.
module smbseq_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  smbseq_pkg::req_t   req_s1,
	output smbseq_pkg::res_t   res
);

	smbseq_pkg::phase_t phase_q, phase_d;
	smbseq_pkg::op_t    held_op_q;
	logic [6:0]         held_addr_q;
	logic [7:0]         held_cmd_q;
	logic [7:0]         held_data_q;
	logic               latch_req;
	smbseq_pkg::kind_t  kind;
	smbseq_pkg::op_t    req_op;
	logic [7:0]         addr_wr;
	logic [7:0]         addr_rd;

	assign kind    = smbseq_pkg::kind_t'(req_s1.kind);
	assign req_op  = smbseq_pkg::op_t'(req_s1.operation);
	assign addr_wr = {held_addr_q, 1'b0} & smbseq_pkg::ADDR_WRITE_MASK;
	assign addr_rd = {held_addr_q, 1'b0} | smbseq_pkg::ADDR_READ_BIT;

	// next phase
	always_comb begin
		phase_d   = phase_q;
		latch_req = 1'b0;
		unique case (kind)
			smbseq_pkg::KIND_REQUEST: begin
				if (phase_q == smbseq_pkg::PH_IDLE) begin
					phase_d   = smbseq_pkg::PH_START;
					latch_req = 1'b1;
				end
			end
			smbseq_pkg::KIND_TIMEOUT: begin
				phase_d = smbseq_pkg::PH_IDLE;
			end
			smbseq_pkg::KIND_STEP: begin
				unique case (phase_q)
					smbseq_pkg::PH_START: phase_d = smbseq_pkg::PH_ADDR;
					smbseq_pkg::PH_ADDR: begin
						if (!req_s1.ack_seen)
							phase_d = smbseq_pkg::PH_IDLE;
						else if (held_op_q == smbseq_pkg::OP_WRITE_BYTE)
							phase_d = smbseq_pkg::PH_DATA;
						else if (held_op_q == smbseq_pkg::OP_READ_BYTE)
							phase_d = smbseq_pkg::PH_RECV;
						else
							phase_d = smbseq_pkg::PH_CMD;
					end
					smbseq_pkg::PH_CMD: begin
						if (!req_s1.ack_seen)
							phase_d = smbseq_pkg::PH_IDLE;
						else if (held_op_q == smbseq_pkg::OP_WRITE_CMD)
							phase_d = smbseq_pkg::PH_DATA;
						else
							phase_d = smbseq_pkg::PH_RSTART;
					end
					smbseq_pkg::PH_RSTART: phase_d = smbseq_pkg::PH_RADDR;
					smbseq_pkg::PH_RADDR: begin
						phase_d = req_s1.ack_seen ? smbseq_pkg::PH_RECV
						                          : smbseq_pkg::PH_IDLE;
					end
					default: phase_d = smbseq_pkg::PH_IDLE;
				endcase
			end
			default: ;
		endcase
	end

	// result of this event
	always_comb begin
		res            = '0;
		res.bus_action = smbseq_pkg::ACT_NONE;
		res.status     = smbseq_pkg::ST_OK;
		unique case (kind)
			smbseq_pkg::KIND_REQUEST: begin
				if (phase_q == smbseq_pkg::PH_IDLE) begin
					res.bus_action = smbseq_pkg::ACT_START;
				end else begin
					res.done_res = 1'b1;
					res.status   = smbseq_pkg::ST_BUSY;
				end
			end
			smbseq_pkg::KIND_TIMEOUT: begin
				if (phase_q != smbseq_pkg::PH_IDLE) begin
					res.done_res = 1'b1;
					res.status   = smbseq_pkg::ST_TIMEOUT;
				end
			end
			smbseq_pkg::KIND_STEP: begin
				unique case (phase_q)
					smbseq_pkg::PH_START: begin
						res.bus_action = smbseq_pkg::ACT_SEND;
						res.bus_byte = (held_op_q == smbseq_pkg::OP_READ_BYTE) ? addr_rd
						                                                       : addr_wr;
					end
					smbseq_pkg::PH_ADDR: begin
						if (!req_s1.ack_seen) begin
							res.bus_action = smbseq_pkg::ACT_STOP;
							res.done_res   = 1'b1;
							res.status     = smbseq_pkg::ST_ADDR_NACK;
						end else if (held_op_q == smbseq_pkg::OP_WRITE_BYTE) begin
							res.bus_action = smbseq_pkg::ACT_SEND;
							res.bus_byte   = held_data_q;
						end else if (held_op_q == smbseq_pkg::OP_READ_BYTE) begin
							res.bus_action = smbseq_pkg::ACT_RECV;
						end else begin
							res.bus_action = smbseq_pkg::ACT_SEND;
							res.bus_byte   = held_cmd_q;
						end
					end
					smbseq_pkg::PH_CMD: begin
						if (!req_s1.ack_seen) begin
							res.bus_action = smbseq_pkg::ACT_STOP;
							res.done_res   = 1'b1;
							res.status     = smbseq_pkg::ST_BYTE2_NACK;
						end else if (held_op_q == smbseq_pkg::OP_WRITE_CMD) begin
							res.bus_action = smbseq_pkg::ACT_SEND;
							res.bus_byte   = held_data_q;
						end else begin
							res.bus_action = smbseq_pkg::ACT_START;
						end
					end
					smbseq_pkg::PH_DATA: begin
						res.bus_action = smbseq_pkg::ACT_STOP;
						res.done_res   = 1'b1;
						if (!req_s1.ack_seen)
							res.status = (held_op_q == smbseq_pkg::OP_WRITE_CMD)
							             ? smbseq_pkg::ST_BYTE3_NACK
							             : smbseq_pkg::ST_BYTE2_NACK;
					end
					smbseq_pkg::PH_RSTART: begin
						res.bus_action = smbseq_pkg::ACT_SEND;
						res.bus_byte   = addr_rd;
					end
					smbseq_pkg::PH_RADDR: begin
						if (!req_s1.ack_seen) begin
							res.bus_action = smbseq_pkg::ACT_STOP;
							res.done_res   = 1'b1;
							res.status     = smbseq_pkg::ST_ADDR_NACK;
						end else begin
							res.bus_action = smbseq_pkg::ACT_RECV;
						end
					end
					smbseq_pkg::PH_RECV: begin
						res.bus_action = smbseq_pkg::ACT_STOP;
						res.done_res   = 1'b1;
						res.read_data  = req_s1.received_byte;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= smbseq_pkg::PH_IDLE;
			held_op_q   <= smbseq_pkg::OP_WRITE_BYTE;
			held_addr_q <= '0;
			held_cmd_q  <= '0;
			held_data_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			if (latch_req) begin
				held_op_q   <= req_op;
				held_addr_q <= req_s1.target_addr;
				held_cmd_q  <= req_s1.command;
				held_data_q <= req_s1.write_data;
			end
		end
	end

endmodule

// ===== sv/smbseq_out_reg.sv =====
// Result register stage of the SMBus sequencer.
// Depends on smbseq_pkg for the result struct.
module smbseq_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  smbseq_pkg::res_t   res,
	input  logic               out_stall,
	output logic               out_ready,
	output logic               valid_s2,
	output smbseq_pkg::res_t   res_s2
);

	// take a new result when empty or when the held one leaves this cycle
	assign out_ready = !valid_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_ready) begin
			valid_s2 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && fire) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== sv/smbus_master_transaction_sequencer.sv =====
// SMBus master transaction sequencer, byte level: top level.
// The input register and the result register separate the two channels, and phase decode
// plus byte select sit between them; a request passes both registers to reach the output.
// Throughput: one request per cycle while out_stall does not hold the result register.
// Reset (arst_n low, asynchronous): both stages empty, phase idle, held fields zero.
// Depends on smbseq_pkg, smbseq_in_reg, smbseq_core and smbseq_out_reg.
module smbus_master_transaction_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [1:0] operation,
	input  logic [6:0] target_addr,
	input  logic [7:0] command,
	input  logic [7:0] write_data,
	input  logic       ack_seen,
	input  logic [7:0] received_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] bus_action,
	output logic [7:0] bus_byte,
	output logic       done_res,
	output logic [2:0] status,
	output logic [7:0] read_data
);

	smbseq_pkg::req_t req;
	smbseq_pkg::req_t req_s1;
	smbseq_pkg::res_t res;
	smbseq_pkg::res_t res_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic             out_ready;
	logic             fire;

	// gather the request fields
	assign req.kind          = kind;
	assign req.operation     = operation;
	assign req.target_addr   = target_addr;
	assign req.command       = command;
	assign req.write_data    = write_data;
	assign req.ack_seen      = ack_seen;
	assign req.received_byte = received_byte;

	// Stage 1: register the incoming request; stall only when both
	// registers are full and the consumer holds the result.
	smbseq_in_reg u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req       (req),
		.out_ready (out_ready),
		.valid_s1  (valid_s1),
		.req_s1    (req_s1)
	);

	// Advance the phase machine exactly when the stage-1 request moves
	// into the result register, so state and results stay in step.
	assign fire = valid_s1 && out_ready;

	smbseq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req_s1 (req_s1),
		.res    (res)
	);

	// Stage 2: result register facing the bus engine.
	smbseq_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res       (res),
		.out_stall (out_stall),
		.out_ready (out_ready),
		.valid_s2  (valid_s2),
		.res_s2    (res_s2)
	);

	assign out_valid  = valid_s2;
	assign bus_action = res_s2.bus_action;
	assign bus_byte   = res_s2.bus_byte;
	assign done_res   = res_s2.done_res;
	assign status     = res_s2.status;
	assign read_data  = res_s2.read_data;

endmodule

// ===== sv/smbseq_chk.sv =====
// Port-level checker for the SMBus sequencer, bound to the top level.
// Depends on smbseq_pkg for action and status codes.
module smbseq_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] bus_action,
	input logic [7:0] bus_byte,
	input logic       done_res,
	input logic [2:0] status,
	input logic [7:0] read_data
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// status only accompanies a finished transaction
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == smbseq_pkg::ST_OK)
		else $error("status without done");

	// a byte is only presented with a send action
	a_byte_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bus_action != smbseq_pkg::ACT_SEND |-> bus_byte == 8'd0)
		else $error("bus byte without send");

	// busy or timeout finish without touching the bus; others close with a stop
	a_done_action: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |->
			((status == smbseq_pkg::ST_BUSY || status == smbseq_pkg::ST_TIMEOUT) &&
			 bus_action == smbseq_pkg::ACT_NONE) ||
			(status != smbseq_pkg::ST_BUSY && status != smbseq_pkg::ST_TIMEOUT &&
			 bus_action == smbseq_pkg::ACT_STOP))
		else $error("done with wrong bus action");

	// read data only on a successful finish
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_data != 8'd0 |-> done_res && status == smbseq_pkg::ST_OK)
		else $error("read data outside successful finish");

endmodule

bind smbus_master_transaction_sequencer smbseq_chk u_smbseq_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.bus_action (bus_action),
	.bus_byte   (bus_byte),
	.done_res   (done_res),
	.status     (status),
	.read_data  (read_data)
);
